// ===== sv/i2c_eeprom_master_macros.svh =====
// Assertion macros for the EEPROM master
`ifndef I2C_EEPROM_MASTER_MACROS_SVH
`define I2C_EEPROM_MASTER_MACROS_SVH
// implication checked on every edge outside reset
`define IEM_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define IEM_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== sv/iem_pkg.sv =====
// ----------------------------------------------------------------------------
// iem_pkg
// Types and constants shared by the EEPROM master.
// ----------------------------------------------------------------------------
package iem_pkg;
    localparam int PAGE_SIZE = 64;
    localparam int PAGE_W = $clog2(PAGE_SIZE + 1);
    localparam logic [6:0] DEV_ADDR_RESET = 7'd80;
    localparam logic [19:0] WAIT_RESET = 20'd20000;
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_WAIT = 1'b1;

    typedef struct packed {
        logic        cmd_valid;
        logic        op;
        logic [15:0] start_address;
        logic [15:0] count_minus_one;
        logic        wr_valid;
        logic [7:0]  wr_byte;
        logic        sda_in;
    } iem_in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       need_data;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       slave_nack;
        logic       busy_res;
        logic       done_res;
    } iem_out_t;
endpackage

// ===== sv/iem_queue.sv =====
// ----------------------------------------------------------------------------
// iem_queue
// Two-entry queue of tick items between the front and the sequencer.
// ----------------------------------------------------------------------------
module iem_queue import iem_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  iem_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output iem_in_t out_data
);
    iem_in_t     mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_data;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== sv/iem_seq.sv =====
// ----------------------------------------------------------------------------
// iem_seq
// Bus sequencer: one pin step per tick, with an output register stage.
// ----------------------------------------------------------------------------
module iem_seq import iem_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  iem_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output iem_out_t    out_data
);
    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_SEND, PH_RACK, PH_NEED,
        PH_RHEAD, PH_RECV, PH_SACK, PH_STOP, PH_WAIT
    } phase_t;
    typedef enum logic [2:0] {
        R_DEVW, R_AH, R_AL, R_DATA, R_DEVR
    } role_t;

    phase_t      phase_reg, phase_next;
    role_t       role_reg, role_next;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  sh_reg, sh_next;
    logic [15:0] addr_reg, addr_next;
    logic [16:0] left_reg, left_next;
    logic        rd_reg, rd_next;
    logic [19:0] wait_reg, wait_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic        scl_reg, scl_next, sda_reg, sda_next;
    logic [6:0]  dev_reg;
    logic [19:0] pwait_reg;
    logic        ov_reg;
    iem_out_t    od_reg, od_next;
    logic        go;
    logic [PAGE_W-1:0] page_room;
    logic [16:0] left_dec;
    logic [PAGE_W-1:0] page_dec;

    assign in_ready  = !ov_reg || out_ready;
    assign go        = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    // address is unchanged since the transaction began when this is used
    assign page_room = PAGE_W'(PAGE_SIZE) - PAGE_W'(addr_reg % PAGE_SIZE);

    always_comb begin
        phase_next = phase_reg; role_next = role_reg; step_next = step_reg;
        bit_next = bit_reg; sh_next = sh_reg; addr_next = addr_reg;
        left_next = left_reg; rd_next = rd_reg; wait_next = wait_reg;
        page_next = page_reg; scl_next = scl_reg; sda_next = sda_reg;
        od_next = '0;
        left_dec = (left_reg != 17'd0) ? left_reg - 17'd1 : left_reg;
        page_dec = (page_reg != '0) ? page_reg - PAGE_W'(1) : page_reg;
        case (phase_reg)
            PH_IDLE: if (in_data.cmd_valid) begin
                addr_next = in_data.start_address;
                left_next = {1'b0, in_data.count_minus_one} + 17'd1;
                rd_next = in_data.op;
                phase_next = PH_START; step_next = '0; role_next = R_DEVW;
            end
            PH_START: begin
                case (step_reg)
                    3'd0: begin sda_next = 1'b1; step_next = 3'd1; end
                    3'd1: begin scl_next = 1'b1; step_next = 3'd2; end
                    3'd2: begin sda_next = 1'b0; step_next = 3'd3; end
                    default: begin
                        scl_next = 1'b0;
                        sh_next = {dev_reg, role_reg == R_DEVR};
                        phase_next = PH_SEND; bit_next = '0; step_next = '0;
                    end
                endcase
            end
            PH_SEND: begin
                if (!bit_reg[3]) begin
                    case (step_reg)
                        3'd0: begin sda_next = sh_reg[3'd7 - bit_reg[2:0]]; step_next = 3'd1; end
                        3'd1: begin scl_next = 1'b1; step_next = 3'd2; end
                        default: begin
                            scl_next = 1'b0; step_next = '0; bit_next = bit_reg + 4'd1;
                        end
                    endcase
                end else if (step_reg == 3'd0) begin
                    scl_next = 1'b0; step_next = 3'd1;
                end else begin
                    sda_next = 1'b1; phase_next = PH_RACK; step_next = '0;
                end
            end
            PH_RACK: begin
                case (step_reg)
                    3'd0: begin sda_next = 1'b1; step_next = 3'd1; end
                    3'd1: begin scl_next = 1'b1; step_next = 3'd2; end
                    3'd2: begin od_next.slave_nack = in_data.sda_in; step_next = 3'd3; end
                    default: begin
                        scl_next = 1'b0; step_next = '0;
                        case (role_reg)
                            R_DEVW: begin
                                role_next = R_AH; sh_next = addr_reg[15:8];
                                phase_next = PH_SEND; bit_next = '0;
                            end
                            R_AH: begin
                                role_next = R_AL; sh_next = addr_reg[7:0];
                                phase_next = PH_SEND; bit_next = '0;
                            end
                            R_AL: begin
                                if (rd_reg) begin
                                    role_next = R_DEVR; phase_next = PH_START;
                                end else begin
                                    role_next = R_DATA; phase_next = PH_NEED;
                                    page_next = (left_reg < {{(17-PAGE_W){1'b0}}, page_room}) ?
                                        PAGE_W'(left_reg) : page_room;
                                end
                            end
                            R_DATA: begin
                                addr_next = addr_reg + 16'd1;
                                left_next = left_dec; page_next = page_dec;
                                phase_next = (page_dec == '0 || left_dec == 17'd0) ?
                                    PH_STOP : PH_NEED;
                            end
                            default: phase_next = PH_RHEAD;
                        endcase
                    end
                endcase
            end
            PH_NEED: begin
                od_next.need_data = 1'b1;
                if (in_data.wr_valid) begin
                    sh_next = in_data.wr_byte; phase_next = PH_SEND;
                    bit_next = '0; step_next = '0;
                end
            end
            PH_RHEAD: begin
                sda_next = 1'b1; sh_next = '0; phase_next = PH_RECV;
                bit_next = '0; step_next = '0;
            end
            PH_RECV: begin
                if (!bit_reg[3]) begin
                    case (step_reg)
                        3'd0: begin scl_next = 1'b1; step_next = 3'd1; end
                        3'd1: begin sh_next = {sh_reg[6:0], in_data.sda_in}; step_next = 3'd2; end
                        default: begin
                            scl_next = 1'b0; step_next = '0; bit_next = bit_reg + 4'd1;
                        end
                    endcase
                end else if (step_reg == 3'd0) begin
                    scl_next = 1'b0; step_next = 3'd1;
                end else begin
                    sda_next = 1'b1;
                    od_next.rx_valid = 1'b1;
                    od_next.rx_byte = sh_reg;
                    od_next.rx_last = (left_reg <= 17'd1);
                    phase_next = PH_SACK; step_next = '0;
                end
            end
            PH_SACK: begin
                case (step_reg)
                    3'd0: begin sda_next = (left_reg <= 17'd1); step_next = 3'd1; end
                    3'd1: begin scl_next = 1'b1; step_next = 3'd2; end
                    default: begin
                        scl_next = 1'b0; step_next = '0;
                        left_next = left_dec; addr_next = addr_reg + 16'd1;
                        phase_next = (left_dec == 17'd0) ? PH_STOP : PH_RHEAD;
                    end
                endcase
            end
            PH_STOP: begin
                case (step_reg)
                    3'd0: begin sda_next = 1'b0; step_next = 3'd1; end
                    3'd1: begin scl_next = 1'b1; step_next = 3'd2; end
                    default: begin
                        sda_next = 1'b1; step_next = '0;
                        if (rd_reg) begin
                            left_next = '0; phase_next = PH_IDLE; od_next.done_res = 1'b1;
                        end else if (pwait_reg != 20'd0) begin
                            wait_next = pwait_reg; phase_next = PH_WAIT;
                        end else if (left_reg == 17'd0) begin
                            phase_next = PH_IDLE; od_next.done_res = 1'b1;
                        end else begin
                            phase_next = PH_START; role_next = R_DEVW;
                        end
                    end
                endcase
            end
            PH_WAIT: begin
                wait_next = (wait_reg != 20'd0) ? wait_reg - 20'd1 : wait_reg;
                if (wait_next == 20'd0) begin
                    step_next = '0;
                    if (left_reg == 17'd0) begin
                        phase_next = PH_IDLE; od_next.done_res = 1'b1;
                    end else begin
                        phase_next = PH_START; role_next = R_DEVW;
                    end
                end
            end
            default: begin phase_next = PH_IDLE; step_next = '0; end
        endcase
        od_next.scl = scl_next;
        od_next.sda_out = sda_next;
        od_next.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (go) od_reg <= od_next;
        if (!aresetn) begin
            phase_reg <= PH_IDLE; role_reg <= R_DEVW; step_reg <= '0; bit_reg <= '0;
            sh_reg <= '0; addr_reg <= '0; left_reg <= '0; rd_reg <= 1'b0;
            wait_reg <= '0; page_reg <= '0; scl_reg <= 1'b1; sda_reg <= 1'b1;
            dev_reg <= DEV_ADDR_RESET; pwait_reg <= WAIT_RESET; ov_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_DEV_ADDR) dev_reg <= cfg_data[6:0];
            if (cfg_we && cfg_index == CFG_WAIT) pwait_reg <= cfg_data;
            if (go) begin
                phase_reg <= phase_next; role_reg <= role_next; step_reg <= step_next;
                bit_reg <= bit_next; sh_reg <= sh_next; addr_reg <= addr_next;
                left_reg <= left_next; rd_reg <= rd_next; wait_reg <= wait_next;
                page_reg <= page_next; scl_reg <= scl_next; sda_reg <= sda_next;
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/i2c_eeprom_master.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_master
// Pin-level I2C master for a two-byte-addressed EEPROM.
// ----------------------------------------------------------------------------
// Each transfer on s_ is one bus timing tick carrying command, write byte and
// the sampled SDA level; each transfer on m_ gives the SCL/SDA drive and
// status for that tick. One result per tick, in order.
// A two-entry queue feeds a sequencer which advances one pin step per tick and
// registers its result; a tick is stored in the queue, then the sequencer takes it
// and registers its result; a tick can be taken every cycle while m_ready is high.
// Write bursts split at page boundaries; each write stop is followed by the
// configured program wait if nonzero. Registers: index 0 device address, 1 wait
// ticks, written via cfg_we/cfg_index/cfg_data while idle (user's duty, unchecked).
// Reset leaves the bus released, the sequencer idle and the queue empty.
// When m_ready is low the result is held, the queue fills and s_ready drops.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_master_macros.svh"
module i2c_eeprom_master import iem_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  iem_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output iem_out_t    m_data
);
    logic    q_valid, q_ready;
    iem_in_t q_data;

    iem_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    iem_seq u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(m_data)
    );

    `IEM_ASSERT_IMP(a_rx_idle, aclk, aresetn, m_valid && m_data.rx_valid, m_data.busy_res)
    `IEM_ASSERT_IMP(a_need_low, aclk, aresetn, m_valid && m_data.need_data, !m_data.scl)
    `IEM_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Tick-level test of the EEPROM I2C master: every tick transfer is run through
// a local model of the sequencer and each result transfer is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
    import iem_pkg::*;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_START, SQ_SEND, SQ_RACK, SQ_NEED, SQ_RHEAD, SQ_RECV,
        SQ_SACK, SQ_STOP, SQ_WAIT
    } seq_phase_e;
    typedef enum logic [2:0] {
        BY_DEVW, BY_AH, BY_AL, BY_DATA, BY_DEVR
    } byte_role_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_DEV_ADDR;
    logic [19:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    iem_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    iem_out_t    m_data;

    i2c_eeprom_master u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    // model state
    logic [6:0]  dev_addr_q;
    logic [19:0] wait_ticks_q;
    seq_phase_e  ph;
    logic [2:0]  step;
    logic [3:0]  nbit;
    logic [7:0]  shreg;
    logic [15:0] addr;
    logic [16:0] left;
    logic        is_read;
    logic [19:0] wcnt;
    byte_role_e  role;
    logic [16:0] page_left;
    logic        scl_l, sda_l;

    iem_out_t pin_queue[$];
    int  errors = 0;
    int  n_results = 0;
    int  n_rx = 0;
    int  n_done = 0;
    bit  no_idle = 0;
    bit  sda_mode_rand = 1;   // random sda_in, otherwise ack low
    longint cycles = 0;

    task automatic report_mismatch(input string what, input iem_out_t got, input iem_out_t exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    function automatic void model_reset();
        dev_addr_q = DEV_ADDR_RESET; wait_ticks_q = WAIT_RESET;
        ph = SQ_IDLE; step = 0; nbit = 0; shreg = 0; addr = 0; left = 0;
        is_read = 0; wcnt = 0; role = BY_DEVW; page_left = 0; scl_l = 1; sda_l = 1;
    endfunction

    function automatic void load_byte(input logic [7:0] b);
        shreg = b; ph = SQ_SEND; nbit = 0; step = 0;
    endfunction

    function automatic void open_txn();
        logic [16:0] room;
        room = 17'(PAGE_SIZE) - 17'(addr % PAGE_SIZE);
        page_left = (left < room) ? left : room;
        role = BY_DEVW; ph = SQ_START; step = 0;
    endfunction

    function automatic iem_out_t tick_model(input iem_in_t t);
        iem_out_t r;
        r = '0;
        case (ph)
            SQ_IDLE: if (t.cmd_valid) begin
                addr = t.start_address; left = 17'(t.count_minus_one) + 17'd1;
                is_read = t.op; open_txn();
            end
            SQ_START: begin
                if (step == 0) begin sda_l = 1; step = 1; end
                else if (step == 1) begin scl_l = 1; step = 2; end
                else if (step == 2) begin sda_l = 0; step = 3; end
                else begin
                    scl_l = 0;
                    load_byte({dev_addr_q, role == BY_DEVR});
                end
            end
            SQ_SEND: begin
                if (nbit < 8) begin
                    if (step == 0) begin sda_l = shreg[7 - nbit]; step = 1; end
                    else if (step == 1) begin scl_l = 1; step = 2; end
                    else begin scl_l = 0; step = 0; nbit++; end
                end else if (step == 0) begin scl_l = 0; step = 1; end
                else begin sda_l = 1; ph = SQ_RACK; step = 0; end
            end
            SQ_RACK: begin
                if (step == 0) begin sda_l = 1; step = 1; end
                else if (step == 1) begin scl_l = 1; step = 2; end
                else if (step == 2) begin r.slave_nack = t.sda_in; step = 3; end
                else begin
                    scl_l = 0; step = 0;
                    case (role)
                        BY_DEVW: begin role = BY_AH; load_byte(addr[15:8]); end
                        BY_AH: begin role = BY_AL; load_byte(addr[7:0]); end
                        BY_AL: if (is_read) begin
                            role = BY_DEVR; ph = SQ_START; step = 0;
                        end else begin
                            role = BY_DATA; ph = SQ_NEED;
                        end
                        BY_DATA: begin
                            addr = addr + 16'd1;
                            if (left != 0) left--;
                            if (page_left != 0) page_left--;
                            if (page_left == 0 || left == 0) begin ph = SQ_STOP; step = 0; end
                            else ph = SQ_NEED;
                        end
                        default: ph = SQ_RHEAD;
                    endcase
                end
            end
            SQ_NEED: begin
                r.need_data = 1;
                if (t.wr_valid) load_byte(t.wr_byte);
            end
            SQ_RHEAD: begin
                sda_l = 1; shreg = 0; ph = SQ_RECV; nbit = 0; step = 0;
            end
            SQ_RECV: begin
                if (nbit < 8) begin
                    if (step == 0) begin scl_l = 1; step = 1; end
                    else if (step == 1) begin shreg = {shreg[6:0], t.sda_in}; step = 2; end
                    else begin scl_l = 0; step = 0; nbit++; end
                end else if (step == 0) begin scl_l = 0; step = 1; end
                else begin
                    sda_l = 1; r.rx_valid = 1; r.rx_byte = shreg; r.rx_last = (left <= 1);
                    ph = SQ_SACK; step = 0;
                end
            end
            SQ_SACK: begin
                if (step == 0) begin sda_l = (left <= 1); step = 1; end
                else if (step == 1) begin scl_l = 1; step = 2; end
                else begin
                    scl_l = 0; step = 0;
                    if (left != 0) left--;
                    addr = addr + 16'd1;
                    ph = (left == 0) ? SQ_STOP : SQ_RHEAD;
                end
            end
            SQ_STOP: begin
                if (step == 0) begin sda_l = 0; step = 1; end
                else if (step == 1) begin scl_l = 1; step = 2; end
                else begin
                    sda_l = 1; step = 0;
                    if (is_read) begin left = 0; ph = SQ_IDLE; r.done_res = 1; end
                    else if (wait_ticks_q != 0) begin wcnt = wait_ticks_q; ph = SQ_WAIT; end
                    else if (left == 0) begin ph = SQ_IDLE; r.done_res = 1; end
                    else open_txn();
                end
            end
            SQ_WAIT: begin
                if (wcnt != 0) wcnt--;
                if (wcnt == 0) begin
                    if (left == 0) begin ph = SQ_IDLE; r.done_res = 1; end
                    else open_txn();
                end
            end
            default: begin ph = SQ_IDLE; step = 0; end
        endcase
        r.scl = scl_l; r.sda_out = sda_l; r.busy_res = (ph != SQ_IDLE);
        return r;
    endfunction

    // send one tick transfer, with an optional random gap first;
    // valid stays high after the transfer until the next tick or an idle call
    task automatic send_tick(input iem_in_t t);
        int gap;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= t;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pin_queue.push_back(tick_model(t));
        @(negedge aclk);
    endtask

    // random filler fields; sda_in follows the selected mode
    function automatic iem_in_t noise_tick();
        iem_in_t t;
        t = iem_in_t'($bits(iem_in_t)'({$urandom, $urandom}));
        t.cmd_valid = 0;
        t.wr_valid = ($urandom_range(0, 3) != 0);
        if (!sda_mode_rand) t.sda_in = 0;
        return t;
    endfunction

    // issue a burst and tick until it completes
    task automatic run_burst(input logic rd, input logic [15:0] a, input logic [15:0] cm1);
        iem_in_t t;
        t = noise_tick();
        t.cmd_valid = 1; t.op = rd; t.start_address = a; t.count_minus_one = cm1;
        send_tick(t);
        while (ph != SQ_IDLE) begin
            t = noise_tick();
            if ($urandom_range(0, 7) == 0) t.cmd_valid = 1;   // ignored while busy
            send_tick(t);
        end
    endtask

    // drop valid and hold until every expected result has come
    task automatic drain();
        s_valid <= 1'b0;
        while (pin_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] v);
        drain();
        @(negedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 0;
        if (idx == CFG_DEV_ADDR) dev_addr_q = v[6:0]; else wait_ticks_q = v;
    endtask

    task automatic test_idle_noise();
        iem_in_t t;
        repeat (6) begin t = noise_tick(); send_tick(t); end
    endtask

    // two-byte write from the top address: wraps and splits into two pages
    task automatic test_page_split();
        sda_mode_rand = 1;
        write_reg(CFG_WAIT, 20'd1);
        write_reg(CFG_DEV_ADDR, 20'h7F);
        run_burst(1'b0, 16'hFFFF, 16'd1);
    endtask

    // two-byte read: first byte acknowledged, last one not
    task automatic test_read_burst();
        write_reg(CFG_DEV_ADDR, 20'h2A);
        no_idle = 1;
        run_burst(1'b1, 16'hFFFF, 16'd1);
    endtask

    // result side: random stalls, compare against oldest expectation
    initial begin
        int stall;
        iem_out_t exp;
        forever begin
            @(negedge aclk);
            if (!no_idle && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 13);
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                n_results++;
                if (pin_queue.size() == 0) begin
                    report_mismatch("unexpected result", m_data, '0);
                end else begin
                    exp = pin_queue.pop_front();
                    if (m_data !== exp) report_mismatch("tick result", m_data, exp);
                    if (exp.rx_valid) n_rx++;
                    if (exp.done_res) n_done++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 64'd200000) begin
            $display("timeout");
            $display("i2c_eeprom_master test failed");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_noise();
        test_page_split();
        test_read_burst();
        drain();
        if (pin_queue.size() != 0) errors++;
        $display("covered %0d tick results, %0d received bytes, %0d bursts finished",
            n_results, n_rx, n_done);
        $display("exercised idle noise, a wrapping page-split write and an acked read");
        if (errors == 0) begin
            $display("i2c_eeprom_master test passed");
        end else begin
            $display("i2c_eeprom_master test failed");
        end
        $finish;
    end
endmodule
